@@ design/clfw_pkg.sv @@
// Package for the character display frame write sequencer: types, constants, register codes.
package clfw_pkg;

	// Sizing of the stacked display set
	localparam int unsigned MAX_DISPLAYS = 8;
	localparam int unsigned MAX_LINES    = 64;

	// Field widths
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned ADDR_W     = 7;
	localparam int unsigned DISP_W     = 4;
	localparam int unsigned SIZE_W     = 7;
	localparam int unsigned OFF_W      = 7;

	// Display addressing constants
	localparam logic [7:0]        CMD_SET_ADDR  = 8'h80;
	localparam logic [ADDR_W-1:0] ODD_LINE_BASE = 7'h40;
	localparam logic [POS_W-1:0]  SPLIT_WIDTH   = 6'd16;
	localparam logic [POS_W-1:0]  SPLIT_COL     = 6'd8;
	localparam logic [3:0]        NIBBLE_MAX    = 4'd9;
	localparam logic [POS_W-1:0]  ROW_MAX       = POS_W'(MAX_LINES - 1);

	// Register reset values
	localparam logic [POS_W-1:0]      RST_LINE_WIDTH = 6'd20;
	localparam logic [CFG_DATA_W-1:0] RST_SPAN_SIZES = 32'd2;
	localparam logic [POS_W-1:0]      RST_WIN_LEFT   = 6'd0;
	localparam logic [POS_W-1:0]      RST_WIN_RIGHT  = 6'd19;
	localparam logic [POS_W-1:0]      RST_WIN_TOP    = 6'd0;
	localparam logic [POS_W-1:0]      RST_WIN_BOTTOM = 6'd1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 3'd0,
		REG_SPAN_SIZES = 3'd1,
		REG_WIN_LEFT   = 3'd2,
		REG_WIN_RIGHT  = 3'd3,
		REG_WIN_TOP    = 3'd4,
		REG_WIN_BOTTOM = 3'd5
	} reg_idx_t;

	// Resolved target of one row
	typedef struct packed {
		logic [DISP_W-1:0] disp;
		logic [ADDR_W-1:0] addr;
	} loc_t;

endpackage

@@ design/char_lcd_frame_write_sequencer_core.sv @@
// Top level of the character display frame write sequencer.
// A data write passes from the first stage into the result register; at the first character
// of a row the set-address write enters the result register ahead of it.
// Throughput: one character per cycle while out_ready stays high; the first character of each
// window row yields a set-address write and a data write, so it holds the input while both go out.
// Reset (arst_n low, asynchronous): registers return to their defaults, the window
// position goes to its first column and row, and both stages empty.
module char_lcd_frame_write_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [clfw_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [clfw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_code,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [clfw_pkg::DISP_W-1:0]       display_id,
	output logic                              is_data,
	output logic [7:0]                        write_byte,
	output logic                              last,
	output logic                              frame_end
);

	logic [clfw_pkg::POS_W-1:0]      line_width_q;
	logic [clfw_pkg::CFG_DATA_W-1:0] span_sizes_q;
	logic [clfw_pkg::POS_W-1:0]      win_left_q;
	logic [clfw_pkg::POS_W-1:0]      win_right_q;
	logic [clfw_pkg::POS_W-1:0]      win_top_q;
	logic [clfw_pkg::POS_W-1:0]      win_bottom_q;
	logic [clfw_pkg::POS_W-1:0]      col_q;
	logic [clfw_pkg::POS_W-1:0]      row_q;

	logic                            valid_s1;
	logic [7:0]                      char_s1;
	logic [clfw_pkg::POS_W-1:0]      row_s1;
	logic                            first_s1;
	logic                            fend_s1;
	logic                            phase_q;

	logic                            out_valid_q;
	logic [clfw_pkg::DISP_W-1:0]     disp_q;
	logic                            is_data_q;
	logic [7:0]                      byte_q;
	logic                            last_q;
	logic                            fend_q;

	logic [clfw_pkg::POS_W-1:0]      span_w;
	logic [clfw_pkg::POS_W-1:0]      span_h;
	logic [clfw_pkg::POS_W:0]        row_sum;
	logic [clfw_pkg::POS_W-1:0]      row_sat;
	logic                            row_end;
	logic                            frame_last;
	logic                            in_fire;
	logic                            load_out;
	logic                            send_data;
	logic                            s1_done;
	clfw_pkg::loc_t                  loc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= clfw_pkg::RST_LINE_WIDTH;
			span_sizes_q <= clfw_pkg::RST_SPAN_SIZES;
			win_left_q   <= clfw_pkg::RST_WIN_LEFT;
			win_right_q  <= clfw_pkg::RST_WIN_RIGHT;
			win_top_q    <= clfw_pkg::RST_WIN_TOP;
			win_bottom_q <= clfw_pkg::RST_WIN_BOTTOM;
		end else if (cfg_we) begin
			case (cfg_idx)
				clfw_pkg::REG_LINE_WIDTH: line_width_q <= cfg_wdata[clfw_pkg::POS_W-1:0];
				clfw_pkg::REG_SPAN_SIZES: span_sizes_q <= cfg_wdata;
				clfw_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_wdata[clfw_pkg::POS_W-1:0];
				clfw_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_wdata[clfw_pkg::POS_W-1:0];
				clfw_pkg::REG_WIN_TOP:    win_top_q    <= cfg_wdata[clfw_pkg::POS_W-1:0];
				clfw_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_wdata[clfw_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Window position: row and frame end, virtual row with saturation
	always_comb begin
		span_w     = (win_right_q >= win_left_q) ? (win_right_q - win_left_q) : '0;
		span_h     = (win_bottom_q >= win_top_q) ? (win_bottom_q - win_top_q) : '0;
		row_sum    = {1'b0, win_top_q} + {1'b0, row_q};
		row_sat    = (row_sum > {1'b0, clfw_pkg::ROW_MAX}) ? clfw_pkg::ROW_MAX :
		             row_sum[clfw_pkg::POS_W-1:0];
		row_end    = col_q >= span_w;
		frame_last = row_end && (row_q >= span_h);
	end

	// Handshake: the first stage drains once its data write enters the result register
	always_comb begin
		load_out  = valid_s1 && (!out_valid_q || out_ready);
		send_data = !first_s1 || phase_q;
		s1_done   = load_out && send_data;
		in_ready  = !valid_s1 || s1_done;
		in_fire   = in_valid && in_ready;
	end

	// Advance the window position on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (frame_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + clfw_pkg::POS_W'(1);
			end else begin
				col_q <= col_q + clfw_pkg::POS_W'(1);
			end
		end
	end

	// First stage: hold the character with its row and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				phase_q <= 1'b0;
			end else if (load_out) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1  <= char_code;
			row_s1   <= row_sat;
			first_s1 <= (col_q == '0);
			fend_s1  <= frame_last;
		end
	end

	clfw_locate u_locate (
		.row        (row_s1),
		.span_sizes (span_sizes_q),
		.line_width (line_width_q),
		.win_left   (win_left_q),
		.loc        (loc)
	);

	// Result register: set-address write first at a row start, then the data write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			disp_q <= loc.disp;
			if (send_data) begin
				is_data_q <= 1'b1;
				byte_q    <= char_s1;
				last_q    <= 1'b1;
				fend_q    <= fend_s1;
			end else begin
				is_data_q <= 1'b0;
				byte_q    <= clfw_pkg::CMD_SET_ADDR | {1'b0, loc.addr};
				last_q    <= 1'b0;
				fend_q    <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign display_id = disp_q;
	assign is_data    = is_data_q;
	assign write_byte = byte_q;
	assign last       = last_q;
	assign frame_end  = fend_q;

	// Checks
	a_phase_only_on_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_s1 && first_s1))
		else $error("second-write phase without a pending row start");

	a_instr_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !is_data) |=> (out_valid && is_data))
		else $error("set-address write not followed by its data write");

	a_instr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_data) |-> (!last && !frame_end && write_byte[7]))
		else $error("malformed set-address write");

	a_data_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_data) |-> last)
		else $error("data write not marked last");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_last) |=> (col_q == '0 && row_q == '0))
		else $error("window position not cleared at frame end");

endmodule

@@ design/clfw_locate.sv @@
// Row locator: maps a virtual row to its display and the set-address position.
module clfw_locate (
	input  logic [clfw_pkg::POS_W-1:0]      row,
	input  logic [clfw_pkg::CFG_DATA_W-1:0] span_sizes,
	input  logic [clfw_pkg::POS_W-1:0]      line_width,
	input  logic [clfw_pkg::POS_W-1:0]      win_left,
	output clfw_pkg::loc_t                  loc
);

	logic [clfw_pkg::OFF_W-1:0]  off;
	logic [clfw_pkg::OFF_W-1:0]  lim;
	logic [3:0]                  nib;
	logic                        found;
	logic                        stop;
	logic [clfw_pkg::DISP_W-1:0] disp;
	logic [clfw_pkg::POS_W-1:0]  rel;
	logic [clfw_pkg::SIZE_W-1:0] size;
	logic [clfw_pkg::POS_W-1:0]  x;
	logic [1:0]                  line;
	logic [7:0]                  addr_sum;

	// Walk the span list: stop at an empty nibble, keep the last display for rows beyond it
	always_comb begin
		off   = '0;
		found = 1'b0;
		stop  = 1'b0;
		disp  = clfw_pkg::DISP_W'(1);
		rel   = row;
		size  = clfw_pkg::SIZE_W'(clfw_pkg::MAX_LINES);
		lim   = '0;
		nib   = '0;
		for (int k = 0; k < clfw_pkg::MAX_DISPLAYS; k++) begin
			nib = span_sizes[4*k +: 4];
			if (!stop) begin
				if (nib == 4'd0) begin
					stop = 1'b1;
				end else begin
					if (nib > clfw_pkg::NIBBLE_MAX) begin
						nib = clfw_pkg::NIBBLE_MAX;
					end
					if (!found) begin
						disp = clfw_pkg::DISP_W'(k + 1);
						rel  = row - clfw_pkg::POS_W'(off);
						size = clfw_pkg::SIZE_W'(nib);
						lim  = off + clfw_pkg::OFF_W'(nib);
						if ({1'b0, row} < lim) begin
							found = 1'b1;
						end
					end
					off = off + clfw_pkg::OFF_W'(nib);
				end
			end
		end
	end

	// Form the display address, splitting a 16-wide single-line display at column 8
	always_comb begin
		x    = win_left;
		line = rel[1:0];
		if (size == clfw_pkg::SIZE_W'(1) && line_width == clfw_pkg::SPLIT_WIDTH &&
		    win_left >= clfw_pkg::SPLIT_COL) begin
			x    = win_left - clfw_pkg::SPLIT_COL;
			line = 2'd1;
		end
		addr_sum = {2'b00, x};
		if (line[0]) begin
			addr_sum = addr_sum + {1'b0, clfw_pkg::ODD_LINE_BASE};
		end
		if (line[1]) begin
			addr_sum = addr_sum + {2'b00, line_width};
		end
		loc.disp = disp;
		loc.addr = addr_sum[clfw_pkg::ADDR_W-1:0];
	end

endmodule

@@ bench/char_lcd_frame_write_sequencer_core_test.sv @@
// Self-checking testbench for the character display frame write sequencer core.
module char_lcd_frame_write_sequencer_core_test;

	localparam int unsigned RAND_CHARS  = 1500;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned SETTLE      = 4;

	// One display write as it leaves the block
	typedef struct packed {
		logic [clfw_pkg::DISP_W-1:0] disp;
		logic                        is_data;
		logic [7:0]                  wbyte;
		logic                        fin;
		logic                        fend;
	} lcd_write_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [clfw_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [clfw_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            in_valid;
	logic                            in_ready;
	logic [7:0]                      char_code;
	logic                            out_valid;
	logic                            out_ready;
	logic [clfw_pkg::DISP_W-1:0]     display_id;
	logic                            is_data;
	logic [7:0]                      write_byte;
	logic                            last;
	logic                            frame_end;

	// Register shadow and window position tracked by the predictor
	logic [clfw_pkg::POS_W-1:0]      line_w;
	logic [clfw_pkg::CFG_DATA_W-1:0] span_cfg;
	logic [clfw_pkg::POS_W-1:0]      win_l, win_r, win_t, win_b;
	logic [clfw_pkg::POS_W-1:0]      col_pos, row_pos;

	lcd_write_t  pending_writes[$];
	int unsigned err_count;
	int unsigned chars_accepted;
	int unsigned writes_checked;
	int unsigned frames_done;
	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          hold_req;

	char_lcd_frame_write_sequencer_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.display_id (display_id),
		.is_data    (is_data),
		.write_byte (write_byte),
		.last       (last),
		.frame_end  (frame_end)
	);

	always #10 clk = ~clk;

	// Random character code
	function automatic logic [7:0] rand_char();
		return 8'($urandom_range(255));
	endfunction

	// Work out the display writes of one accepted character and advance the position
	function automatic void predict_char_writes(input logic [7:0] code);
		int unsigned span_w, span_h, y, nib, off, last_off, last_size, count;
		int unsigned disp, rel, size, x, line, addr;
		bit          found, done, row_end, fend;
		lcd_write_t  w;
		span_w = (win_r >= win_l) ? int'(win_r) - int'(win_l) : 0;
		span_h = (win_b >= win_t) ? int'(win_b) - int'(win_t) : 0;
		y = int'(win_t) + int'(row_pos);
		if (y > clfw_pkg::MAX_LINES - 1)
			y = clfw_pkg::MAX_LINES - 1;

		// Walk the span list to find the display holding this row
		off = 0; last_off = 0; last_size = 0; count = 0;
		found = 1'b0; done = 1'b0;
		disp = 1; rel = y; size = clfw_pkg::MAX_LINES;
		for (int k = 0; k < clfw_pkg::MAX_DISPLAYS; k++) begin
			nib = int'((span_cfg >> (4 * k)) & 32'hF);
			if (!done) begin
				if (nib == 0) begin
					done = 1'b1;
				end else begin
					if (nib > int'(clfw_pkg::NIBBLE_MAX))
						nib = int'(clfw_pkg::NIBBLE_MAX);
					count = k + 1;
					last_off = off;
					last_size = nib;
					if (y < off + nib) begin
						disp = count; rel = y - off; size = nib;
						found = 1'b1; done = 1'b1;
					end
					off += nib;
				end
			end
		end
		// Rows past the list stay on the last listed display
		if (!found && count != 0) begin
			disp = count; rel = y - last_off; size = last_size;
		end

		// Set-address write at the first column of a row
		if (col_pos == '0) begin
			x = int'(win_l);
			line = rel;
			if (size == 1 && line_w == clfw_pkg::SPLIT_WIDTH &&
					x >= int'(clfw_pkg::SPLIT_COL)) begin
				x -= int'(clfw_pkg::SPLIT_COL);
				line = 1;
			end
			addr = x + ((line & 1) ? int'(clfw_pkg::ODD_LINE_BASE) : 0);
			if ((line & 3) >= 2)
				addr += int'(line_w);
			w.disp = disp[clfw_pkg::DISP_W-1:0];
			w.is_data = 1'b0;
			w.wbyte = clfw_pkg::CMD_SET_ADDR | {1'b0, addr[clfw_pkg::ADDR_W-1:0]};
			w.fin = 1'b0;
			w.fend = 1'b0;
			pending_writes.push_back(w);
		end

		row_end = int'(col_pos) >= span_w;
		fend = row_end && int'(row_pos) >= span_h;
		w.disp = disp[clfw_pkg::DISP_W-1:0];
		w.is_data = 1'b1;
		w.wbyte = code;
		w.fin = 1'b1;
		w.fend = fend;
		pending_writes.push_back(w);

		// Advance the window position
		if (fend) begin
			col_pos = '0;
			row_pos = '0;
			frames_done++;
		end else if (row_end) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		chars_accepted++;
	endfunction

	// Offer one character, with an optional random gap, and hold it until taken
	task automatic send_char(input logic [7:0] code);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(99) < 30) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid = 1'b1;
		char_code = code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_char_writes(code);
	endtask

	// Drop valid and wait until every expected write has come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one register once the block is idle, and mirror it in the shadow
	task automatic write_reg(input clfw_pkg::reg_idx_t idx,
			input logic [clfw_pkg::CFG_DATA_W-1:0] val);
		wait_idle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			clfw_pkg::REG_LINE_WIDTH: line_w = val[clfw_pkg::POS_W-1:0];
			clfw_pkg::REG_SPAN_SIZES: span_cfg = val;
			clfw_pkg::REG_WIN_LEFT:   win_l = val[clfw_pkg::POS_W-1:0];
			clfw_pkg::REG_WIN_RIGHT:  win_r = val[clfw_pkg::POS_W-1:0];
			clfw_pkg::REG_WIN_TOP:    win_t = val[clfw_pkg::POS_W-1:0];
			clfw_pkg::REG_WIN_BOTTOM: win_b = val[clfw_pkg::POS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input int unsigned l, input int unsigned r,
			input int unsigned t, input int unsigned b);
		write_reg(clfw_pkg::REG_WIN_LEFT, l);
		write_reg(clfw_pkg::REG_WIN_RIGHT, r);
		write_reg(clfw_pkg::REG_WIN_TOP, t);
		write_reg(clfw_pkg::REG_WIN_BOTTOM, b);
	endtask

	// Defaults after reset, with the all-zero and all-one character codes
	task automatic test_reset_window();
		send_char(8'h00);
		send_char(8'hFF);
	endtask

	// Shrink the window mid-row so the current row and then the frame close early
	task automatic test_shrink_mid_frame();
		write_reg(clfw_pkg::REG_WIN_RIGHT, 0);
		send_char(8'hA5);
		send_char(8'h5A);
	endtask

	// Reversed bounds collapse the window to a single character
	task automatic test_reversed_window();
		set_window(5, 2, 3, 1);
		send_char(8'h31);
		send_char(8'hCE);
	endtask

	// Single-line 16-wide displays take the right half on line 1
	task automatic test_split_display();
		write_reg(clfw_pkg::REG_LINE_WIDTH, 16);
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'h1111_1111);
		set_window(10, 11, 0, 1);
		repeat (4) send_char(rand_char());
	endtask

	// Push the virtual row past the last line so it saturates
	task automatic test_row_saturation();
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'h0);
		set_window(0, 0, 0, 63);
		repeat (6) send_char(rand_char());
		set_window(0, 0, 62, 63);
		send_char(rand_char());
	endtask

	// Clipped nibbles, eighth display, address wrap and rows past a short span list
	task automatic test_span_list_edges();
		write_reg(clfw_pkg::REG_LINE_WIDTH, 40);
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'hFFFF_FFFF);
		set_window(39, 39, 3, 3);
		send_char(rand_char());
		set_window(39, 39, 63, 63);
		send_char(rand_char());
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'h21);
		set_window(7, 7, 5, 5);
		send_char(rand_char());
		// Empty list: one display of many lines, never split
		write_reg(clfw_pkg::REG_LINE_WIDTH, 16);
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'h0);
		set_window(9, 9, 1, 1);
		send_char(rand_char());
	endtask

	// Receiver holds off for a long stretch while characters keep coming
	task automatic test_back_pressure();
		write_reg(clfw_pkg::REG_LINE_WIDTH, 20);
		write_reg(clfw_pkg::REG_SPAN_SIZES, 32'h0000_0424);
		set_window(2, 5, 0, 5);
		hold_req = 1'b1;
		repeat (48) send_char(rand_char());
		wait_idle();
	endtask

	// Full rate on both sides for a long run
	task automatic test_no_idle_stretch();
		set_window(0, 3, 1, 4);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (200) send_char(rand_char());
		wait_idle();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Random settings; mostly whole frames, some broken frames and a few large windows
	task automatic test_random_frames();
		int unsigned start, lft, rgt, top, bot, area, goal;
		logic [clfw_pkg::CFG_DATA_W-1:0] spans;
		start = chars_accepted;
		while (chars_accepted < start + RAND_CHARS) begin
			case ($urandom_range(4))
				0: write_reg(clfw_pkg::REG_LINE_WIDTH, 1);
				1: write_reg(clfw_pkg::REG_LINE_WIDTH, 40);
				2: write_reg(clfw_pkg::REG_LINE_WIDTH, 16);
				3: write_reg(clfw_pkg::REG_LINE_WIDTH, $urandom_range(1, 40));
				default: write_reg(clfw_pkg::REG_LINE_WIDTH, $urandom_range(63));
			endcase
			case ($urandom_range(5))
				0: spans = '0;
				1: spans = '1;
				2: spans = $urandom();
				3: spans = 32'h1111_1111;
				default: begin
					spans = '0;
					for (int k = $urandom_range(1, 8); k > 0; k--)
						spans = (spans << 4) | $urandom_range(1, 4);
				end
			endcase
			write_reg(clfw_pkg::REG_SPAN_SIZES, spans);
			if ($urandom_range(19) == 0) begin
				lft = $urandom_range(63);
				rgt = $urandom_range(63);
				top = $urandom_range(63);
				bot = $urandom_range(63);
			end else begin
				lft = $urandom_range(39);
				rgt = ($urandom_range(7) == 0) ? $urandom_range(lft) : lft + $urandom_range(7);
				top = $urandom_range(63);
				bot = ($urandom_range(7) == 0) ? $urandom_range(top) : top + $urandom_range(4);
				if (bot > 63)
					bot = 63;
			end
			set_window(lft, rgt, top, bot);
			area = ((rgt >= lft) ? rgt - lft + 1 : 1) * ((bot >= top) ? bot - top + 1 : 1);
			if (area <= 64 && $urandom_range(4) != 0) begin
				goal = frames_done + $urandom_range(1, (96 / area > 1) ? 96 / area : 1);
				while (frames_done < goal)
					send_char(rand_char());
			end else begin
				repeat ($urandom_range(1, 40)) send_char(rand_char());
			end
		end
		wait_idle();
	endtask

	// Receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready = !(rx_idle_en && $urandom_range(99) < 30);
			end
		end
	end

	// Compare each result transaction with the oldest expected write
	always @(posedge clk) begin : check_writes
		lcd_write_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write: id %0d data %0b byte %h last %0b frame_end %0b",
					$time, display_id, is_data, write_byte, last, frame_end);
				err_count++;
			end else begin
				exp_w = pending_writes.pop_front();
				if (exp_w.disp !== display_id || exp_w.is_data !== is_data ||
						exp_w.wbyte !== write_byte || exp_w.fin !== last ||
						exp_w.fend !== frame_end) begin
					$display("%0t: mismatch: expected id %0d data %0b byte %h last %0b frame_end %0b",
						$time, exp_w.disp, exp_w.is_data, exp_w.wbyte, exp_w.fin, exp_w.fend);
					$display("%0t:           actual   id %0d data %0b byte %h last %0b frame_end %0b",
						$time, display_id, is_data, write_byte, last, frame_end);
					err_count++;
				end
				writes_checked++;
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = clfw_pkg::REG_LINE_WIDTH;
		cfg_wdata = '0;
		in_valid = 1'b0;
		char_code = 8'h00;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req = 1'b0;
		err_count = 0;
		chars_accepted = 0;
		writes_checked = 0;
		frames_done = 0;
		line_w = clfw_pkg::RST_LINE_WIDTH;
		span_cfg = clfw_pkg::RST_SPAN_SIZES;
		win_l = clfw_pkg::RST_WIN_LEFT;
		win_r = clfw_pkg::RST_WIN_RIGHT;
		win_t = clfw_pkg::RST_WIN_TOP;
		win_b = clfw_pkg::RST_WIN_BOTTOM;
		col_pos = '0;
		row_pos = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_window();
		test_shrink_mid_frame();
		test_reversed_window();
		test_split_display();
		test_row_saturation();
		test_span_list_edges();
		test_back_pressure();
		test_no_idle_stretch();
		test_random_frames();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run: %0d characters sent, %0d display writes checked, %0d frames closed",
			chars_accepted, writes_checked, frames_done);
		$display("Run: window edges, split and wrapped addresses, span list ends, hold-off");
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/clfw_pkg.sv
design/clfw_locate.sv
design/char_lcd_frame_write_sequencer_core.sv
bench/char_lcd_frame_write_sequencer_core_test.sv
